>>> hdl/gbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_pkg: shared types and constants of the gravity body euler step block
// item layouts, mode codes, register indexes and the sequencer states
// ----------------------------------------------------------------------------
package gbe_pkg;

	localparam int WORD_W    = 48;  // width of every body word
	localparam int GRAV_W    = 48;  // gravitational constant, unsigned q8.40
	localparam int GRAV_FRAC = 40;
	localparam int SUBST_W   = 25;  // zero distance substitute, q1.24
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;

	localparam logic [GRAV_W-1:0]  GRAV_RESET  = GRAV_W'(64'd1099511627776);
	localparam logic [SUBST_W-1:0] SUBST_RESET = SUBST_W'(167772);

	localparam logic [CFG_IDX_W-1:0] CFG_GRAV  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBST = 1'b1;

	localparam logic [2:0] MODE_LOAD     = 3'd0;
	localparam logic [2:0] MODE_SET_POS  = 3'd1;
	localparam logic [2:0] MODE_SET_MASS = 3'd2;
	localparam logic [2:0] MODE_SET_ACC  = 3'd3;
	localparam logic [2:0] MODE_GRAVITY  = 3'd4;
	localparam logic [2:0] MODE_TICK     = 3'd5;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0]        mass_in;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] acc_x;
		logic signed [WORD_W-1:0] acc_y;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] out_pos_x;
		logic signed [WORD_W-1:0] out_pos_y;
		logic signed [WORD_W-1:0] out_vel_x;
		logic signed [WORD_W-1:0] out_vel_y;
		logic signed [WORD_W-1:0] out_acc_x;
		logic signed [WORD_W-1:0] out_acc_y;
		logic [WORD_W-1:0]        out_mass;
		logic [WORD_W-1:0]        pair_distance;
		logic                     saturated;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_R2,
		ST_R3,
		ST_GM,
		ST_NUMX,
		ST_DIVX,
		ST_NUMY,
		ST_DIVY,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

>>> hdl/gravity_body_euler_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gravity_body_euler_step: one 2-d body under explicit euler integration
// holds position, velocity, acceleration and mass; adds the pull of other
// bodies through serial multiply, square root and divide units
// ----------------------------------------------------------------------------
//  channel   signals                          direction  item
//  req       req_valid req_stall req_data     in         mode and body fields
//  rsp       rsp_valid rsp_stall rsp_data     out        body after the step
//  cfg       cfg_valid cfg_ready cfg_index    in         grav const, substitute
//            cfg_data
//
//  modes other than gravity: the item goes straight to the finish state, and
//  the result is registered there once the output register is free
//  gravity mode walks seven serial multiplies, one square root and two divides,
//  each a start, word+1 bits at one bit per cycle and done, on 48-bit words
//  one item at a time; the next item is accepted once the result is registered
//  a stalled result holds in the output register, the next item still runs
//  reset clears the body to zero and loads the register defaults
// ----------------------------------------------------------------------------
module gravity_body_euler_step #(
	parameter int FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  gbe_pkg::req_t                     req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output gbe_pkg::rsp_t                     rsp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gbe_pkg::*;

	localparam int W   = WORD_W;
	localparam int RW  = W + 1;                 // distance needs one extra bit
	localparam int PW  = (3*RW > GRAV_W + 2*W) ? 3*RW : GRAV_W + 2*W;
	// cancel the common power of two between numerator and denominator
	localparam int NUM_SH = (2*FRAC_BITS > GRAV_FRAC) ? 2*FRAC_BITS - GRAV_FRAC : 0;
	localparam int DEN_SH = (GRAV_FRAC > 2*FRAC_BITS) ? GRAV_FRAC - 2*FRAC_BITS : 0;
	localparam int NW  = PW + NUM_SH;
	localparam int AW  = 3*RW + DEN_SH + W;
	localparam int DW  = (NW > AW) ? NW : AW;

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	// saturating signed add, flag in the top bit
	function automatic logic [W:0] sat_add(input logic signed [W-1:0] a,
	                                       input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return {1'b1, (s[W] ? SMIN : SMAX)};
		return {1'b0, s[W-1:0]};
	endfunction

	// sequencer
	state_t state_q, state_d;
	logic   launch_q, launch_d;
	logic   acc_req;
	logic   out_free;

	// configuration
	logic [GRAV_W-1:0]  grav_q;
	logic [SUBST_W-1:0] subst_q;

	// body state
	logic signed [W-1:0] body_x_q, body_y_q, body_vx_q, body_vy_q, body_ax_q, body_ay_q;
	logic [W-1:0]        body_mass_q;

	// working registers of one item
	req_t               item_q;
	logic [W-1:0]       mx_q, my_q;
	logic               nx_q, ny_q;
	logic [2*W-1:0]     sqx_q;
	logic [2*RW-1:0]    s_q;
	logic [RW-1:0]      r_q;
	logic [2*RW-1:0]    r2_q;
	logic [3*RW-1:0]    r3_q;
	logic [GRAV_W+W-1:0] gm_q;
	logic [PW-1:0]      num_q;
	logic signed [W-1:0] incx_q, incy_q;
	logic [W-1:0]       dist_q;
	logic               flag_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	// unit hookup
	logic          mul_start, sqrt_start, div_start;
	logic [PW-1:0] mul_a, mul_prod;
	logic [RW-1:0] mul_b;
	logic          mul_done, sqrt_done, div_done;
	logic [RW-1:0] sqrt_root;
	logic [RW-1:0] div_quo;
	logic [DW-1:0] div_num, div_den;

	// difference of the other body against own position
	logic signed [W:0] dpx, dpy;

	// distance after the coincident-body substitution
	logic [SUBST_W-1:0] subst_eff;
	logic [RW-1:0]      r_eff;

	// quotient clamp
	logic          neg_sel;
	logic [W-1:0]  lim;
	logic          qsat;
	logic [W-1:0]  qmag;
	logic [W-1:0]  inc_w;

	// next body and result
	rsp_t rsp_d;
	logic [W:0] sa0, sa1, sa2, sa3;

	assign cfg_ready = 1'b1;
	assign acc_req   = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
		end
	end

	// next state, unit starts and multiplier operand choice
	always_comb begin
		state_d  = state_q;
		launch_d = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_data.mode == MODE_GRAVITY) begin
						state_d  = ST_SQX;
						launch_d = 1'b1;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SQX: begin
				mul_a = PW'(mx_q);
				mul_b = RW'(mx_q);
				if (mul_done) begin
					state_d  = ST_SQY;
					launch_d = 1'b1;
				end
			end
			ST_SQY: begin
				mul_a = PW'(my_q);
				mul_b = RW'(my_q);
				if (mul_done) begin
					state_d  = ST_SQRT;
					launch_d = 1'b1;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d  = ST_R2;
					launch_d = 1'b1;
				end
			end
			ST_R2: begin
				mul_a = PW'(r_q);
				mul_b = r_q;
				if (mul_done) begin
					state_d  = ST_R3;
					launch_d = 1'b1;
				end
			end
			ST_R3: begin
				mul_a = PW'(r2_q);
				mul_b = r_q;
				if (mul_done) begin
					state_d  = ST_GM;
					launch_d = 1'b1;
				end
			end
			ST_GM: begin
				mul_a = PW'(grav_q);
				mul_b = RW'(item_q.mass_in);
				if (mul_done) begin
					state_d  = ST_NUMX;
					launch_d = 1'b1;
				end
			end
			ST_NUMX: begin
				mul_a = PW'(gm_q);
				mul_b = RW'(mx_q);
				if (mul_done) begin
					state_d  = ST_DIVX;
					launch_d = 1'b1;
				end
			end
			ST_DIVX: begin
				if (div_done) begin
					state_d  = ST_NUMY;
					launch_d = 1'b1;
				end
			end
			ST_NUMY: begin
				mul_a = PW'(gm_q);
				mul_b = RW'(my_q);
				if (mul_done) begin
					state_d  = ST_DIVY;
					launch_d = 1'b1;
				end
			end
			ST_DIVY: begin
				if (div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mul_start  = launch_q && (state_q == ST_SQX || state_q == ST_SQY ||
	                    state_q == ST_R2 || state_q == ST_R3 || state_q == ST_GM ||
	                    state_q == ST_NUMX || state_q == ST_NUMY);
	assign sqrt_start = launch_q && (state_q == ST_SQRT);
	assign div_start  = launch_q && (state_q == ST_DIVX || state_q == ST_DIVY);

	assign div_num = DW'(num_q) << NUM_SH;
	assign div_den = DW'(r3_q) << (DEN_SH + W);

	gbe_smul #(.PW(PW), .BW(RW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .prod(mul_prod), .done(mul_done)
	);

	gbe_sqrt #(.RW(RW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.rad(s_q), .root(sqrt_root), .done(sqrt_done)
	);

	gbe_div #(.DW(DW), .QW(RW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den_al(div_den), .quo(div_quo), .done(div_done)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q  <= GRAV_RESET;
			subst_q <= SUBST_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GRAV:  grav_q  <= cfg_data[GRAV_W-1:0];
				CFG_SUBST: subst_q <= cfg_data[SUBST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dpx = {req_data.pos_x[W-1], req_data.pos_x} - {body_x_q[W-1], body_x_q};
		dpy = {req_data.pos_y[W-1], req_data.pos_y} - {body_y_q[W-1], body_y_q};
	end

	// coincident bodies use the substitute, a zero substitute acts as one lsb
	always_comb begin
		subst_eff = (subst_q == '0) ? SUBST_W'(1) : subst_q;
		r_eff     = (sqrt_root == '0) ? RW'(subst_eff) : sqrt_root;
	end

	// clamp the quotient to the signed range, then apply the sign of d
	always_comb begin
		neg_sel = (state_q == ST_DIVY) ? ny_q : nx_q;
		lim     = neg_sel ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		qsat    = div_quo[W] || (div_quo[W-1:0] > lim);
		qmag    = qsat ? lim : div_quo[W-1:0];
		inc_w   = neg_sel ? (~qmag + 1'b1) : qmag;
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (acc_req) begin
			item_q <= req_data;
			nx_q   <= dpx[W];
			ny_q   <= dpy[W];
			mx_q   <= dpx[W] ? W'(-dpx) : dpx[W-1:0];
			my_q   <= dpy[W] ? W'(-dpy) : dpy[W-1:0];
			flag_q <= 1'b0;
			dist_q <= '0;
			incx_q <= '0;
			incy_q <= '0;
		end
		if (mul_done) begin
			unique case (state_q)
				ST_SQX:  sqx_q <= mul_prod[2*W-1:0];
				ST_SQY:  s_q   <= (2*RW)'(sqx_q) + (2*RW)'(mul_prod[2*W-1:0]);
				ST_R2:   r2_q  <= mul_prod[2*RW-1:0];
				ST_R3:   r3_q  <= mul_prod[3*RW-1:0];
				ST_GM:   gm_q  <= mul_prod[GRAV_W+W-1:0];
				ST_NUMX: num_q <= mul_prod;
				ST_NUMY: num_q <= mul_prod;
				default: ;
			endcase
		end
		if (sqrt_done) begin
			r_q <= r_eff;
			// distance beyond the word reports all ones
			if (r_eff[W]) begin
				dist_q <= '1;
				flag_q <= 1'b1;
			end else begin
				dist_q <= r_eff[W-1:0];
			end
		end
		if (div_done) begin
			if (state_q == ST_DIVX)
				incx_q <= inc_w;
			else
				incy_q <= inc_w;
			if (qsat)
				flag_q <= 1'b1;
		end
	end

	// body after the step
	always_comb begin
		sa0 = '0;
		sa1 = '0;
		sa2 = '0;
		sa3 = '0;
		rsp_d.out_pos_x     = body_x_q;
		rsp_d.out_pos_y     = body_y_q;
		rsp_d.out_vel_x     = body_vx_q;
		rsp_d.out_vel_y     = body_vy_q;
		rsp_d.out_acc_x     = body_ax_q;
		rsp_d.out_acc_y     = body_ay_q;
		rsp_d.out_mass      = body_mass_q;
		rsp_d.pair_distance = dist_q;
		rsp_d.saturated     = 1'b0;
		unique case (item_q.mode)
			MODE_LOAD: begin
				rsp_d.out_pos_x = item_q.pos_x;
				rsp_d.out_pos_y = item_q.pos_y;
				rsp_d.out_vel_x = item_q.vel_x;
				rsp_d.out_vel_y = item_q.vel_y;
				rsp_d.out_acc_x = '0;
				rsp_d.out_acc_y = '0;
				rsp_d.out_mass  = item_q.mass_in;
			end
			MODE_SET_POS: begin
				rsp_d.out_pos_x = item_q.pos_x;
				rsp_d.out_pos_y = item_q.pos_y;
			end
			MODE_SET_MASS: rsp_d.out_mass = item_q.mass_in;
			MODE_SET_ACC: begin
				rsp_d.out_acc_x = item_q.acc_x;
				rsp_d.out_acc_y = item_q.acc_y;
			end
			MODE_GRAVITY: begin
				sa0 = sat_add(body_ax_q, incx_q);
				sa1 = sat_add(body_ay_q, incy_q);
				rsp_d.out_acc_x = sa0[W-1:0];
				rsp_d.out_acc_y = sa1[W-1:0];
				rsp_d.saturated = flag_q | sa0[W] | sa1[W];
			end
			MODE_TICK: begin
				// position takes the old velocity
				sa0 = sat_add(body_x_q, body_vx_q);
				sa1 = sat_add(body_y_q, body_vy_q);
				sa2 = sat_add(body_vx_q, body_ax_q);
				sa3 = sat_add(body_vy_q, body_ay_q);
				rsp_d.out_pos_x = sa0[W-1:0];
				rsp_d.out_pos_y = sa1[W-1:0];
				rsp_d.out_vel_x = sa2[W-1:0];
				rsp_d.out_vel_y = sa3[W-1:0];
				rsp_d.out_acc_x = '0;
				rsp_d.out_acc_y = '0;
				rsp_d.saturated = sa0[W] | sa1[W] | sa2[W] | sa3[W];
			end
			default: ;
		endcase
	end

	// commit body and result together once the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_x_q    <= '0;
			body_y_q    <= '0;
			body_vx_q   <= '0;
			body_vy_q   <= '0;
			body_ax_q   <= '0;
			body_ay_q   <= '0;
			body_mass_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (state_q == ST_FIN && out_free) begin
				body_x_q    <= rsp_d.out_pos_x;
				body_y_q    <= rsp_d.out_pos_y;
				body_vx_q   <= rsp_d.out_vel_x;
				body_vy_q   <= rsp_d.out_vel_y;
				body_ax_q   <= rsp_d.out_acc_x;
				body_ay_q   <= rsp_d.out_acc_y;
				body_mass_q <= rsp_d.out_mass;
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
endmodule
`default_nettype wire

>>> hdl/gbe_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_smul: serial shift-add multiplier
// one multiplier bit per cycle, product width PW, multiplier width BW
// ----------------------------------------------------------------------------
module gbe_smul #(
	parameter int PW = 147,
	parameter int BW = 49
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [PW-1:0] prod,
	output logic          done
);
	localparam int CW = (BW > 1) ? $clog2(BW) : 1;

	logic [PW-1:0] acc_q;
	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> hdl/gbe_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_sqrt: digit-by-digit integer square root
// one root bit per cycle from two radicand bits, floor result
// ----------------------------------------------------------------------------
module gbe_sqrt #(
	parameter int RW = 49
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root,
	output logic            done
);
	localparam int CW = (RW > 1) ? $clog2(RW) : 1;

	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+3:0]   rem_w;
	logic [RW+3:0]   trial;
	logic [RW+3:0]   rem_nx;
	logic            ge;

	always_comb begin
		rem_w  = {rem_q, rad_q[2*RW-1 -: 2]};
		trial  = (RW+4)'({root_q, 2'b01});
		ge     = (rem_w >= trial);
		rem_nx = ge ? (rem_w - trial) : rem_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_nx[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> hdl/gbe_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_div: restoring divider, one quotient bit per cycle
// divisor comes in pre-aligned to the top quotient bit and moves right
// ----------------------------------------------------------------------------
module gbe_div #(
	parameter int DW = 195,
	parameter int QW = 49
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den_al,
	output logic [QW-1:0] quo,
	output logic          done
);
	localparam int CW = (QW > 1) ? $clog2(QW) : 1;

	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = (rem_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			d_q   <= den_al;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - d_q;
			d_q   <= d_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

>>> sim/gbe_body_checker.sv
// ----------------------------------------------------------------------------
// gbe_body_checker: predicts the body after each accepted item
// tracks its own copy of the body and of the two registers, works out the
// expected result of every accepted item and compares it with the response
// ----------------------------------------------------------------------------
module gbe_body_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  gbe_pkg::req_t                  req_data,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  gbe_pkg::rsp_t                  rsp_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbe_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);
	import gbe_pkg::*;

	localparam int FRAC_BITS = 24;

	typedef logic signed [WORD_W-1:0] sword_t;
	localparam sword_t SMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam sword_t SMIN = {1'b1, {(WORD_W-1){1'b0}}};

	sword_t             bx, by, bvx, bvy, bax, bay;
	logic [WORD_W-1:0]  bmass;
	logic [GRAV_W-1:0]  grav;
	logic [SUBST_W-1:0] subst;
	rsp_t               body_after_q[$];

	function automatic sword_t sat_add(sword_t a, sword_t b, inout logic flag);
		logic signed [WORD_W:0] s;
		begin
			s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
			if (s[WORD_W] != s[WORD_W-1]) begin
				flag = 1'b1;
				return s[WORD_W] ? SMIN : SMAX;
			end
			return s[WORD_W-1:0];
		end
	endfunction

	// g*m*|d|*2^48 / (r^3*2^40), truncated, clipped to the signed range
	function automatic sword_t pull(logic [WORD_W:0] mag, logic neg, logic [95:0] gm,
			logic [255:0] den, inout logic flag);
		logic [255:0] num, q, lim;
		begin
			num = (256'(gm) * 256'(mag)) << (2 * FRAC_BITS);
			q = num / den;
			lim = neg ? (256'(1) << (WORD_W-1)) : ((256'(1) << (WORD_W-1)) - 1);
			if (q > lim) begin
				flag = 1'b1;
				q = lim;
			end
			return neg ? -sword_t'(q[WORD_W-1:0]) : sword_t'(q[WORD_W-1:0]);
		end
	endfunction

	task automatic advance_body(input req_t it, output rsp_t res);
		logic               flag;
		logic [WORD_W-1:0]  pair_dist;
		logic signed [WORD_W:0] dx, dy;
		logic [WORD_W:0]    mx, my;
		logic [99:0]        ssum, cand_sq;
		logic [49:0]        r, cand;
		logic [255:0]       den;
		logic [95:0]        gm;
		sword_t             incx, incy;
		begin
			flag = 1'b0;
			pair_dist = '0;
			case (it.mode)
				MODE_LOAD: begin
					bx = it.pos_x; by = it.pos_y; bmass = it.mass_in;
					bvx = it.vel_x; bvy = it.vel_y; bax = '0; bay = '0;
				end
				MODE_SET_POS: begin
					bx = it.pos_x; by = it.pos_y;
				end
				MODE_SET_MASS: bmass = it.mass_in;
				MODE_SET_ACC: begin
					bax = it.acc_x; bay = it.acc_y;
				end
				MODE_GRAVITY: begin
					dx = $signed({it.pos_x[WORD_W-1], it.pos_x}) - $signed({bx[WORD_W-1], bx});
					dy = $signed({it.pos_y[WORD_W-1], it.pos_y}) - $signed({by[WORD_W-1], by});
					mx = dx[WORD_W] ? -dx : dx;
					my = dy[WORD_W] ? -dy : dy;
					ssum = 100'(mx) * 100'(mx) + 100'(my) * 100'(my);
					r = '0;
					for (int b = 49; b >= 0; b--) begin
						cand = r | (50'(1) << b);
						cand_sq = 100'(cand) * 100'(cand);
						if (cand_sq <= ssum) r = cand;
					end
					// coincident bodies use the substitute, zero meaning one lsb
					if (r == 0) r = (subst == 0) ? 50'd1 : 50'(subst);
					if (r > 50'({WORD_W{1'b1}})) begin
						flag = 1'b1;
						pair_dist = '1;
					end else pair_dist = r[WORD_W-1:0];
					den = (256'(r) * 256'(r) * 256'(r)) << GRAV_FRAC;
					gm = 96'(grav) * 96'(it.mass_in);
					incx = pull(mx, dx[WORD_W], gm, den, flag);
					incy = pull(my, dy[WORD_W], gm, den, flag);
					bax = sat_add(bax, incx, flag);
					bay = sat_add(bay, incy, flag);
				end
				MODE_TICK: begin
					bx = sat_add(bx, bvx, flag);
					by = sat_add(by, bvy, flag);
					bvx = sat_add(bvx, bax, flag);
					bvy = sat_add(bvy, bay, flag);
					bax = '0; bay = '0;
				end
				default: ;
			endcase
			res.out_pos_x = bx; res.out_pos_y = by;
			res.out_vel_x = bvx; res.out_vel_y = bvy;
			res.out_acc_x = bax; res.out_acc_y = bay;
			res.out_mass = bmass;
			res.pair_distance = pair_dist;
			res.saturated = flag;
		end
	endtask

	task automatic report(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e, r;
		if (!arst_n) begin
			bmass = '0;
			bx = '0; by = '0; bvx = '0; bvy = '0; bax = '0; bay = '0;
			grav = GRAV_RESET;
			subst = SUBST_RESET;
			fail_count = 0;
			pending = 0;
			body_after_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				r = rsp_data;
				if (body_after_q.size() == 0) begin
					$display("unexpected result item");
					fail_count++;
				end else begin
					e = body_after_q.pop_front();
					if (r.out_pos_x !== e.out_pos_x) report("pos_x", r.out_pos_x, e.out_pos_x);
					if (r.out_pos_y !== e.out_pos_y) report("pos_y", r.out_pos_y, e.out_pos_y);
					if (r.out_vel_x !== e.out_vel_x) report("vel_x", r.out_vel_x, e.out_vel_x);
					if (r.out_vel_y !== e.out_vel_y) report("vel_y", r.out_vel_y, e.out_vel_y);
					if (r.out_acc_x !== e.out_acc_x) report("acc_x", r.out_acc_x, e.out_acc_x);
					if (r.out_acc_y !== e.out_acc_y) report("acc_y", r.out_acc_y, e.out_acc_y);
					if (r.out_mass !== e.out_mass) report("mass", r.out_mass, e.out_mass);
					if (r.pair_distance !== e.pair_distance)
						report("distance", r.pair_distance, e.pair_distance);
					if (r.saturated !== e.saturated)
						report("saturated", 48'(r.saturated), 48'(e.saturated));
				end
			end
			if (req_valid && !req_stall) begin
				advance_body(req_data, e);
				body_after_q.push_back(e);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GRAV) grav = cfg_data[GRAV_W-1:0];
				else if (cfg_index == CFG_SUBST) subst = cfg_data[SUBST_W-1:0];
			end
			pending = body_after_q.size();
		end
	end

endmodule

>>> sim/tb_gravity_body_euler_step.sv
// ----------------------------------------------------------------------------
// tb_gravity_body_euler_step: stimulus and verdict for the euler step block
// runs directed corner items and random body sequences under several register
// settings, with random gaps and stalls; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_gravity_body_euler_step;
	import gbe_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	req_t                    req_data = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	rsp_t                    rsp_data;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	int                      fail_count;
	int                      pending;
	int                      cycles = 0;
	logic                    gaps_on = 1'b1;   // cleared for the quiet stretch

	always #10 clk = ~clk;

	gravity_body_euler_step u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gbe_body_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_gravity_body_euler_step NOT OK");
			$finish;
		end
	end

	// response stalls, drawn with a 22 percent chance outside the quiet stretch
	always @(posedge clk) begin
		rsp_stall <= gaps_on && ($urandom_range(99) < 22);
	end

	// random word: random magnitude class so small and huge values both occur
	function automatic logic [WORD_W-1:0] rand_word(input int sh_lo);
		logic [63:0] v;
		int          sh;
		begin
			v = {$urandom, $urandom};
			sh = $urandom_range(WORD_W - 1, sh_lo);
			if ($urandom_range(9) == 0) return v[WORD_W-1:0];
			v = v & ((64'd1 << sh) - 1);
			return ($urandom_range(1) == 1) ? -v[WORD_W-1:0] : v[WORD_W-1:0];
		end
	endfunction

	function automatic req_t rand_item(input logic [2:0] mode);
		req_t it;
		begin
			it = '0;
			it.mode = mode;
			it.pos_x = rand_word(20);
			it.pos_y = rand_word(20);
			it.mass_in = rand_word(24);
			if ($urandom_range(3) != 0) it.mass_in[WORD_W-1] = 1'b0;
			it.vel_x = rand_word(10);
			it.vel_y = rand_word(10);
			it.acc_x = rand_word(10);
			it.acc_y = rand_word(10);
			return it;
		end
	endfunction

	// one item: optional idle cycles, then hold until accepted
	task automatic send_item(input req_t it);
		while (gaps_on && $urandom_range(99) < 22) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		do @(posedge clk); while (req_stall);
	endtask

	// register write once the block has drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_fields(input logic [2:0] mode, input logic [WORD_W-1:0] px,
			input logic [WORD_W-1:0] py, input logic [WORD_W-1:0] m,
			input logic [WORD_W-1:0] vx, input logic [WORD_W-1:0] vy);
		req_t it;
		it = rand_item(mode);
		it.pos_x = px; it.pos_y = py; it.mass_in = m; it.vel_x = vx; it.vel_y = vy;
		it.acc_x = vx; it.acc_y = vy;
		send_item(it);
	endtask

	// an episode: a load, then one to eight items drawn from pulls, ticks, edits and the unused mode codes 6 and 7
	task automatic episode();
		int n;
		req_t it;
		logic [2:0] md;
		begin
			send_item(rand_item(MODE_LOAD));
			n = $urandom_range(8, 1);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(15))
					0: md = MODE_SET_POS;
					1: md = MODE_SET_MASS;
					2: md = MODE_SET_ACC;
					3: md = 3'($urandom_range(7, 6));
					4, 5, 6, 7: md = MODE_TICK;
					default: md = MODE_GRAVITY;
				endcase
				it = rand_item(md);
				// now and then the other body takes the position of the last reported result
				if (md == MODE_GRAVITY && $urandom_range(9) == 0) begin
					it.pos_x = rsp_data.out_pos_x;
					it.pos_y = rsp_data.out_pos_y;
				end
				send_item(it);
			end
		end
	endtask

	localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] ONE  = 48'd1 << 24;

	task automatic run_random(input int count);
		while (count > 0) begin
			episode();
			count -= 5;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners under the reset register values
		send_fields(MODE_TICK, 0, 0, 0, 0, 0);
		send_fields(MODE_LOAD, WMAX, WMIN, '1, WMAX, WMIN);
		send_fields(MODE_SET_ACC, 0, 0, 0, WMAX, WMIN);
		send_fields(MODE_TICK, 0, 0, 0, 0, 0);          // position and velocity overflow
		send_fields(MODE_GRAVITY, WMIN, WMAX, '1, 0, 0); // distance beyond the word
		send_fields(MODE_LOAD, 0, 0, ONE, ONE, -ONE);
		send_fields(MODE_GRAVITY, 0, 0, ONE, 0, 0);      // coincident bodies
		send_fields(MODE_GRAVITY, 1, 0, '1, 0, 0);       // huge pull, saturates
		send_fields(MODE_GRAVITY, 0, -1, '1, 0, 0);
		send_fields(MODE_GRAVITY, 3 * ONE, 4 * ONE, ONE, 0, 0);
		send_fields(MODE_SET_POS, -ONE, ONE, 0, 0, 0);
		send_fields(MODE_SET_MASS, 0, 0, '1, 0, 0);
		send_fields(MODE_GRAVITY, ONE, -ONE, 5 * ONE, 0, 0);
		send_fields(MODE_TICK, 0, 0, 0, 0, 0);
		send_fields(3'd6, WMAX, WMAX, '1, WMAX, WMAX);
		send_fields(3'd7, WMIN, WMIN, 0, WMIN, WMIN);
		send_fields(MODE_SET_ACC, 0, 0, 0, -1, 1);
		send_fields(MODE_TICK, 0, 0, 0, 0, 0);
		run_random(300);

		// no gravity, smallest substitute
		write_reg(CFG_GRAV, 0);
		write_reg(CFG_SUBST, 1);
		send_fields(MODE_LOAD, 0, 0, ONE, 0, 0);
		send_fields(MODE_GRAVITY, 0, 0, '1, 0, 0);
		run_random(250);

		// strongest gravity, substitute at one; a quiet stretch with no idling
		write_reg(CFG_GRAV, '1);
		write_reg(CFG_SUBST, 48'd16777216);
		gaps_on <= 1'b0;
		run_random(300);
		gaps_on <= 1'b1;

		// substitute written as zero, gravity at one
		write_reg(CFG_SUBST, 0);
		write_reg(CFG_GRAV, 48'd1 << 40);
		send_fields(MODE_LOAD, ONE, ONE, ONE, 0, 0);
		send_fields(MODE_GRAVITY, ONE, ONE, ONE, 0, 0);
		run_random(250);

		// random settings, all bits of both registers exercised
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_GRAV, CFG_DATA_W'({$urandom, $urandom}));
			write_reg(CFG_SUBST, CFG_DATA_W'({$urandom, $urandom}));
			run_random(150);
		end

		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("tb_gravity_body_euler_step OK");
		else
			$display("tb_gravity_body_euler_step NOT OK");
		$finish;
	end

endmodule

>>> gravity_body_euler_step.f
hdl/gbe_pkg.sv
hdl/gbe_smul.sv
hdl/gbe_sqrt.sv
hdl/gbe_div.sv
hdl/gravity_body_euler_step.sv
sim/gbe_body_checker.sv
sim/tb_gravity_body_euler_step.sv
